/* hdl/sust_pkg.sv */
// Shared types and codes for the sorted unique set table.
// Used by sust_ctrl and sorted_unique_set_table_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sust_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_INDEX  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_MISS = 2'd3;

  typedef struct packed {
    logic       modified;
    logic [6:0] entry_count;
    logic [5:0] position;
    logic [1:0] status;
  } sust_res_t;

endpackage

`default_nettype wire

/* hdl/sust_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/sust_ctrl.sv */
// Request sequencer: binary search over the entry RAM, then an insert or
// remove shift pipelined through its one read and one write port.
// Depends on sust_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sust_ctrl import sust_pkg::*; #(
  parameter int CAPACITY     = 64,
  parameter int RECORD_WIDTH = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_op,
  input  wire logic [31:0]                 in_rec,
  output logic                             res_valid,
  input  wire logic                        res_ready,
  output sust_res_t                        res,
  output logic                             mem_we,
  output logic [$clog2(CAPACITY)-1:0]      mem_waddr,
  output logic [RECORD_WIDTH-1:0]          mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr,
  input  wire logic [RECORD_WIDTH-1:0]     mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_INS   = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state;
  logic [1:0]              op;
  logic [RECORD_WIDTH-1:0] key;
  logic [RECORD_WIDTH-1:0] key_in;
  logic [CW-1:0]           count;
  logic                    changed;
  logic [CW-1:0]           lo;
  logic [CW-1:0]           hi;
  logic [CW-1:0]           mid;
  logic [CW-1:0]           mid_r;
  logic                    hit;
  logic [CW-1:0]           idx;
  logic                    wp_vld;
  logic [CW-1:0]           wp_addr;
  logic [1:0]              status;
  logic [AW-1:0]           pos;
  logic                    del_more;

  generate
    if (RECORD_WIDTH > 32) begin : g_key_wide
      assign key_in = {{(RECORD_WIDTH - 32){1'b0}}, in_rec};
    end else begin : g_key_narrow
      assign key_in = in_rec[RECORD_WIDTH-1:0];
    end
  endgenerate

  assign mid      = lo + ((hi - lo) >> 1);
  assign del_more = ({1'b0, idx} + {{CW{1'b0}}, 1'b1}) < {1'b0, count};

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // read address: probe during search, neighbour entry during a shift
  always_comb begin
    mem_raddr = mid[AW-1:0];
    case (state)
      S_INS:   mem_raddr = AW'(idx - CW'(1));
      S_DEL:   mem_raddr = AW'(idx + CW'(1));
      default: mem_raddr = mid[AW-1:0];
    endcase
  end

  // write port: pending shifted beat, or the new key once the gap is open
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_addr[AW-1:0];
    mem_wdata = mem_rdata;
    case (state)
      S_INS: begin
        if (wp_vld) begin
          mem_we = 1'b1;
        end else if (idx == lo) begin
          mem_we    = 1'b1;
          mem_waddr = lo[AW-1:0];
          mem_wdata = key;
        end
      end
      S_DEL: begin
        mem_we = wp_vld;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      changed <= 1'b0;
      wp_vld  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= in_op;
            key    <= key_in;
            lo     <= '0;
            hi     <= count;
            hit    <= 1'b0;
            wp_vld <= 1'b0;
            state  <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid_r <= mid;
            state <= S_CMP;
          end else begin
            status <= STAT_MISS;
            pos    <= '0;
            state  <= S_DONE;
            case (op)
              OP_INSERT: begin
                if (hit) begin
                  status <= STAT_DUP;
                end else if (count == CW'(CAPACITY)) begin
                  status <= STAT_FULL;
                end else begin
                  idx   <= count;
                  state <= S_INS;
                end
              end
              OP_REMOVE: begin
                if (hit) begin
                  idx   <= lo;
                  state <= S_DEL;
                end
              end
              OP_INDEX: begin
                if (hit) begin
                  status <= STAT_OK;
                  pos    <= lo[AW-1:0];
                end
              end
              default: begin
                status <= STAT_MISS;
              end
            endcase
          end
        end
        S_CMP: begin
          // distinct entries: an equal probe is the lower bound itself
          if (key == mem_rdata) begin
            hit <= 1'b1;
          end
          if (key <= mem_rdata) begin
            hi <= mid_r;
          end else begin
            lo <= mid_r + CW'(1);
          end
          state <= S_PROBE;
        end
        S_INS: begin
          if (idx > lo) begin
            wp_vld  <= 1'b1;
            wp_addr <= idx;
            idx     <= idx - CW'(1);
          end else if (wp_vld) begin
            wp_vld <= 1'b0;
          end else begin
            count   <= count + CW'(1);
            changed <= 1'b1;
            status  <= STAT_OK;
            state   <= S_DONE;
          end
        end
        S_DEL: begin
          if (del_more) begin
            wp_vld  <= 1'b1;
            wp_addr <= idx;
            idx     <= idx + CW'(1);
          end else if (wp_vld) begin
            wp_vld <= 1'b0;
          end else begin
            count   <= count - CW'(1);
            changed <= 1'b1;
            status  <= STAT_OK;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.status   = status;
  assign res.modified = changed;

  generate
    if (CW >= 7) begin : g_cnt_wide
      assign res.entry_count = count[6:0];
    end else begin : g_cnt_narrow
      assign res.entry_count = {{(7 - CW){1'b0}}, count};
    end
    if (AW >= 6) begin : g_pos_wide
      assign res.position = pos[5:0];
    end else begin : g_pos_narrow
      assign res.position = {{(6 - AW){1'b0}}, pos};
    end
  endgenerate

endmodule

`default_nettype wire

/* hdl/sorted_unique_set_table_top.sv */
// Top level of the sorted unique set table: stream ports, result register,
// sequencer and entry RAM. Depends on sust_pkg, sust_ctrl and sust_ram.
`timescale 1ns / 1ps
`default_nettype none

//  channel | dir | fields
//  s_axis  | in  | tdata: record_number[31:0]; tuser: operation[1:0]
//  m_axis  | out | tdata: position[5:0], entry_count[12:6], modified[13], zero pad
//          |     | tuser: status[1:0]
//
//  One request at a time. Search: binary search over the n stored entries,
//  one RAM probe and one compare per step. Insert or remove then shifts each
//  entry after the position by one, limited by the single write port.
//  A finished result sits in the output register while the next request is
//  taken; the sequencer stalls only if that register is still full.
//  Reset empties the set and clears the modified flag; RAM contents are not
//  cleared, entries are always written before they are read.
module sorted_unique_set_table_top import sust_pkg::*; #(
  parameter int CAPACITY     = 64,
  parameter int RECORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // record_number[31:0]
  input  wire logic [1:0]  s_axis_tuser,   // operation[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // position[5:0], entry_count[12:6], modified[13]
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  localparam int AW = $clog2(CAPACITY);

  logic                    res_valid;
  logic                    res_ready;
  sust_res_t               res;
  sust_res_t               out_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [RECORD_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [RECORD_WIDTH-1:0] mem_rdata;

  sust_ctrl #(
    .CAPACITY     (CAPACITY),
    .RECORD_WIDTH (RECORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_op     (s_axis_tuser),
    .in_rec    (s_axis_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  sust_ram #(
    .WIDTH (RECORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign m_axis_tdata = {2'b00, out_r.modified, out_r.entry_count, out_r.position};
  assign m_axis_tuser = out_r.status;

endmodule

`default_nettype wire
